/* hdl/parental_origin_pattern_classifier_unit_macros.svh */
// ---------------------------------------------------------------------------
// parental origin pattern classifier assertion macros
// shared concurrent assertion forms, clocked on clock, off during reset
// ---------------------------------------------------------------------------
`ifndef PARENTAL_ORIGIN_PATTERN_CLASSIFIER_UNIT_MACROS_SVH
`define PARENTAL_ORIGIN_PATTERN_CLASSIFIER_UNIT_MACROS_SVH

// property that holds at every edge
`define POPC_ASSERT_NOW(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// property whose consequent holds in the cycle after the antecedent
`define POPC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/popc_pkg.sv */
// ---------------------------------------------------------------------------
// popc_pkg
// types, codes and constants of the parental origin pattern classifier
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package popc_pkg;

   localparam int unsigned MAX_LEN_DEFAULT = 1048576;
   localparam int unsigned CFG_W           = 21;
   localparam int unsigned FIFO_DEPTH      = 4;
   localparam int unsigned FIFO_PTR_W      = 2;
   localparam int unsigned FIFO_CNT_W      = 3;

   localparam logic [CFG_W-1:0] TOTAL_MAX = {CFG_W{1'b1}};

   // register indexes
   localparam logic [1:0] CSR_SEQ_LENGTH     = 2'd0;
   localparam logic [1:0] CSR_END_ZONE       = 2'd1;
   localparam logic [1:0] CSR_MISMATCH_LIMIT = 2'd2;

   // parent codes
   localparam logic [1:0] CODE_NONE = 2'd0;
   localparam logic [1:0] CODE_H    = 2'd1;
   localparam logic [1:0] CODE_L    = 2'd2;

   // position kinds from the front end
   localparam logic [1:0] KIND_MISMATCH = 2'd0;
   localparam logic [1:0] KIND_H        = 2'd1;
   localparam logic [1:0] KIND_L        = 2'd2;
   localparam logic [1:0] KIND_BOTH     = 2'd3;

   localparam logic [2:0] RUN_NEEDED = 3'd7;
   localparam logic [2:0] SWITCH_MAX = 3'd7;

   // pattern codes
   localparam logic [3:0] PAT_H_TWO     = 4'd1;
   localparam logic [3:0] PAT_L_TWO     = 4'd2;
   localparam logic [3:0] PAT_L_THREE   = 4'd3;
   localparam logic [3:0] PAT_H_THREE   = 4'd4;
   localparam logic [3:0] PAT_OTHER     = 4'd5;
   localparam logic [3:0] PAT_H_ONE     = 4'd6;
   localparam logic [3:0] PAT_L_ONE     = 4'd7;
   localparam logic [3:0] PAT_MISMATCH  = 4'd8;
   localparam logic [3:0] PAT_IDENTICAL = 4'd9;
   localparam logic [3:0] PAT_END_RUN   = 4'd10;

   typedef struct packed {
      logic [7:0] f_base;
      logic [7:0] h_base;
      logic [7:0] l_base;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic [3:0]       pattern_code;
      logic [CFG_W-1:0] mismatch_total;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       identical;
      logic       last;
   } op_type;

   typedef struct packed {
      logic [CFG_W-1:0] seq_length;
      logic [CFG_W-1:0] end_zone;
      logic [CFG_W-1:0] mismatch_limit;
   } cfg_type;

endpackage

/* hdl/popc_front.sv */
// ---------------------------------------------------------------------------
// popc_front
// compares the three bases of a position and reduces them to a kind
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module popc_front (
   input  popc_pkg::req_item_type item,
   output popc_pkg::op_type       op
);

   logic fh_eq;
   logic fl_eq;

   assign fh_eq = (item.f_base == item.h_base);
   assign fl_eq = (item.f_base == item.l_base);

   always_comb begin
      op.identical = fh_eq && fl_eq;
      op.last      = item.last;
      if (!fh_eq && !fl_eq) begin
         op.kind = popc_pkg::KIND_MISMATCH;
      end else if (fh_eq && !fl_eq) begin
         op.kind = popc_pkg::KIND_H;
      end else if (fl_eq && !fh_eq) begin
         op.kind = popc_pkg::KIND_L;
      end else begin
         op.kind = popc_pkg::KIND_BOTH;
      end
   end

endmodule

/* hdl/popc_fifo.sv */
// ---------------------------------------------------------------------------
// popc_fifo
// short queue of classified positions between front and back end
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module popc_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  popc_pkg::op_type  push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output popc_pkg::op_type  pop_data
);

   popc_pkg::op_type                        slot_ff [popc_pkg::FIFO_DEPTH];
   logic [popc_pkg::FIFO_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [popc_pkg::FIFO_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [popc_pkg::FIFO_CNT_W-1:0]         count_ff, count_in;

   assign full      = (count_ff == popc_pkg::FIFO_CNT_W'(popc_pkg::FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/popc_back.sv */
// ---------------------------------------------------------------------------
// popc_back
// sequence state update, classification and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "parental_origin_pattern_classifier_unit_macros.svh"

module popc_back #(
   parameter int unsigned MaxLen = popc_pkg::MAX_LEN_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  popc_pkg::cfg_type      cfg,
   input  logic                   op_valid,
   input  popc_pkg::op_type       op,
   output logic                   op_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output popc_pkg::rsp_item_type rsp_data
);

   localparam int unsigned CW   = $clog2(MaxLen) + 1;
   localparam int unsigned CMPW =
      ((CW > popc_pkg::CFG_W) ? CW : popc_pkg::CFG_W) + 1;
   localparam logic [CW-1:0] CNT_SAT = CW'(64'(MaxLen) * 64'd2 - 64'd1);

   logic [CW-1:0] position_ff, position_in;
   logic [CW-1:0] mismatch_ff, mismatch_in;
   logic [1:0]    prev_code_ff, prev_code_in;
   logic [CW-1:0] prev_pos_ff, prev_pos_in;
   logic [2:0]    run_ff, run_in;
   logic          cand_ff, cand_in;
   logic [1:0]    first_code_ff, first_code_in;
   logic [2:0]    switch_ff, switch_in;
   logic          ident_ff, ident_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   popc_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic [3:0]      pattern;
   logic [CMPW:0]   far_sum;
   logic            near;
   logic [1:0]      code;

   assign op_pop    = op_valid && (!op.last || !rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign far_sum = (CMPW + 1)'(position_ff) + (CMPW + 1)'(cfg.end_zone);
   assign near    = (CMPW'(position_ff) <= CMPW'(cfg.end_zone)) ||
                    (far_sum >= (CMPW + 1)'(cfg.seq_length));
   assign code    = (op.kind == popc_pkg::KIND_H) ? popc_pkg::CODE_H :
                    (op.kind == popc_pkg::KIND_L) ? popc_pkg::CODE_L : popc_pkg::CODE_NONE;

   always_comb begin
      position_in   = position_ff;
      mismatch_in   = mismatch_ff;
      prev_code_in  = prev_code_ff;
      prev_pos_in   = prev_pos_ff;
      run_in        = run_ff;
      cand_in       = cand_ff;
      first_code_in = first_code_ff;
      switch_in     = switch_ff;
      ident_in      = ident_ff;
      pattern       = popc_pkg::PAT_OTHER;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (op_pop) begin
         ident_in = ident_ff && op.identical;
         if (op.kind == popc_pkg::KIND_MISMATCH) begin
            if (mismatch_ff != CNT_SAT) begin
               mismatch_in = mismatch_ff + 1'b1;
            end
         end else begin
            if (!near) begin
               run_in = '0;
            end
            if (code != popc_pkg::CODE_NONE) begin
               if (code != prev_code_ff) begin
                  if (near) begin
                     if ((CW + 1)'(position_ff) == (CW + 1)'(prev_pos_ff) + 1'b1) begin
                        if (run_in < popc_pkg::RUN_NEEDED) begin
                           run_in = run_in + 1'b1;
                        end
                     end else begin
                        run_in = '0;
                     end
                     if (run_in >= popc_pkg::RUN_NEEDED) begin
                        cand_in = 1'b1;
                     end
                  end
                  if (first_code_ff == popc_pkg::CODE_NONE) begin
                     first_code_in = code;
                  end
                  if (switch_ff < popc_pkg::SWITCH_MAX) begin
                     switch_in = switch_ff + 1'b1;
                  end
               end
               prev_code_in = code;
               prev_pos_in  = position_ff;
            end
         end
         if (position_ff != CNT_SAT) begin
            position_in = position_ff + 1'b1;
         end

         if (ident_in) begin
            pattern = popc_pkg::PAT_IDENTICAL;
         end else if (CMPW'(mismatch_in) > CMPW'(cfg.mismatch_limit)) begin
            pattern = popc_pkg::PAT_MISMATCH;
         end else if (cand_in) begin
            pattern = popc_pkg::PAT_END_RUN;
         end else begin
            case (switch_in)
               3'd1:    pattern = (first_code_in == popc_pkg::CODE_H) ?
                                  popc_pkg::PAT_H_ONE : popc_pkg::PAT_L_ONE;
               3'd2:    pattern = (first_code_in == popc_pkg::CODE_H) ?
                                  popc_pkg::PAT_H_TWO : popc_pkg::PAT_L_TWO;
               3'd3:    pattern = (first_code_in == popc_pkg::CODE_H) ?
                                  popc_pkg::PAT_H_THREE : popc_pkg::PAT_L_THREE;
               default: pattern = popc_pkg::PAT_OTHER;
            endcase
         end

         if (op.last) begin
            rsp_valid_in                = 1'b1;
            rsp_data_in.pattern_code    = pattern;
            rsp_data_in.mismatch_total  =
               (CMPW'(mismatch_in) > CMPW'(popc_pkg::TOTAL_MAX)) ?
               popc_pkg::TOTAL_MAX : popc_pkg::CFG_W'(mismatch_in);
            position_in   = '0;
            mismatch_in   = '0;
            prev_code_in  = popc_pkg::CODE_NONE;
            prev_pos_in   = '0;
            run_in        = '0;
            cand_in       = 1'b0;
            first_code_in = popc_pkg::CODE_NONE;
            switch_in     = '0;
            ident_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         mismatch_ff   <= '0;
         prev_code_ff  <= popc_pkg::CODE_NONE;
         prev_pos_ff   <= '0;
         run_ff        <= '0;
         cand_ff       <= 1'b0;
         first_code_ff <= popc_pkg::CODE_NONE;
         switch_ff     <= '0;
         ident_ff      <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         position_ff   <= position_in;
         mismatch_ff   <= mismatch_in;
         prev_code_ff  <= prev_code_in;
         prev_pos_ff   <= prev_pos_in;
         run_ff        <= run_in;
         cand_ff       <= cand_in;
         first_code_ff <= first_code_in;
         switch_ff     <= switch_in;
         ident_ff      <= ident_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   `POPC_ASSERT_NOW(a_cand_needs_switches, !cand_ff || (switch_ff == popc_pkg::SWITCH_MAX), "end run flagged without saturated switch count")
   `POPC_ASSERT_NOW(a_first_code_tracks_switches, (first_code_ff == popc_pkg::CODE_NONE) == (switch_ff == 3'd0), "first code and switch count disagree")
   `POPC_ASSERT_NEXT(a_last_clears_sequence, op_pop && op.last, (position_ff == '0) && ident_ff && rsp_valid_ff, "last beat did not clear state and post a result")

endmodule

/* hdl/parental_origin_pattern_classifier_unit.sv */
// ---------------------------------------------------------------------------
// parental origin pattern classifier unit
// streams aligned offspring / parent positions and classifies the sequence
// ---------------------------------------------------------------------------
// One position beat is taken per cycle while the queue is not full. The front
// end compares the three bases and queues the position kind in a four-entry
// queue; the back end updates the sequence state for one queued beat per cycle
// unless a last beat is held, so the sustained rate is one beat per clock. The
// beat flagged last writes its result into the output register at the edge
// that takes it from the queue; an accepted beat passes through a queue slot
// before it reaches the result register. A result still waiting holds back
// only the next last beat, and the next sequence starts behind it with no gap.
// The rate is set by the state update in the back end. Configuration is written
// through the csr port by the user while no sequence is in flight; the block does not enforce this.
`timescale 1ns / 1ps

module parental_origin_pattern_classifier_unit #(
   parameter int unsigned MaxLen = popc_pkg::MAX_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  popc_pkg::req_item_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output popc_pkg::rsp_item_type        rsp_data,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [popc_pkg::CFG_W-1:0]    csr_write_data
);

   popc_pkg::cfg_type cfg_ff, cfg_in;
   popc_pkg::op_type  front_op;
   popc_pkg::op_type  queue_op;
   logic              queue_full;
   logic              queue_not_empty;
   logic              queue_pop;
   logic              queue_push;

   assign req_ready  = !queue_full;
   assign queue_push = req_valid && !queue_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            popc_pkg::CSR_SEQ_LENGTH:     cfg_in.seq_length     = csr_write_data;
            popc_pkg::CSR_END_ZONE:       cfg_in.end_zone       = csr_write_data;
            popc_pkg::CSR_MISMATCH_LIMIT: cfg_in.mismatch_limit = csr_write_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seq_length     <= popc_pkg::CFG_W'(1);
         cfg_ff.end_zone       <= '0;
         cfg_ff.mismatch_limit <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   popc_front u_front (
      .item (req_data),
      .op   (front_op)
   );

   popc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (front_op),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_data  (queue_op)
   );

   popc_back #(
      .MaxLen (MaxLen)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .op_valid  (queue_not_empty),
      .op        (queue_op),
      .op_pop    (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* verif/tb_parental_origin_pattern_classifier_unit.sv */
// ---------------------------------------------------------------------------
// tb_parental_origin_pattern_classifier_unit
// Streams aligned offspring / parent positions into the classifier, predicts
// the pattern code and mismatch total of every sequence, and compares each
// result beat with the oldest prediction. Directed cases first, then random
// sequences under several register settings, with random idling on both
// channels and one long result stall that fills the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_parental_origin_pattern_classifier_unit;
   import popc_pkg::*;

   localparam int DRAIN_CYCLES = 12;
   localparam int LONG_HOLD    = 200;
   localparam int RANDOM_BEATS = 1000;
   localparam int PHASE_BEATS  = 150;

   typedef enum int {SHAPE_RUNS, SHAPE_ALTERNATE, SHAPE_SCRAMBLED, SHAPE_UNIFORM} seq_shape_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_item_type     req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_item_type     rsp_data;
   logic             csr_write_enable = 1'b0;
   logic [1:0]       csr_index = CSR_SEQ_LENGTH;
   logic [CFG_W-1:0] csr_write_data = '0;

   // predictor state
   cfg_type          cfg_shadow;
   logic [CFG_W-1:0] at_position;
   logic [CFG_W-1:0] miss_count;
   logic [1:0]       prev_parent;
   logic [CFG_W-1:0] prev_coded_pos;
   logic [2:0]       adj_run;
   logic             end_run_seen;
   logic [1:0]       first_parent;
   logic [2:0]       switch_total;
   logic             all_same;

   rsp_item_type     pending_patterns[$];
   rsp_item_type     oldest_pattern;
   int               error_count = 0;
   int               beats_sent = 0;
   logic             quiet_mode = 1'b0;
   logic             long_hold_req = 1'b0;

   parental_origin_pattern_classifier_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      #1_000_000;
      $display("tb_parental_origin_pattern_classifier_unit: FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 50) $display("mismatch at %0t: %s", $time, what);
   endtask

   function automatic void clear_lineage();
      at_position    = '0;
      miss_count     = '0;
      prev_parent    = CODE_NONE;
      prev_coded_pos = '0;
      adj_run        = '0;
      end_run_seen   = 1'b0;
      first_parent   = CODE_NONE;
      switch_total   = '0;
      all_same       = 1'b1;
   endfunction

   function automatic void track_position(input req_item_type beat);
      logic [CFG_W:0] pos_ext;
      logic           near_end;
      logic [1:0]     parent;
      rsp_item_type   outcome;
      pos_ext = {1'b0, at_position};
      if (!(beat.f_base == beat.h_base && beat.h_base == beat.l_base)) all_same = 1'b0;
      if (beat.f_base != beat.h_base && beat.f_base != beat.l_base) begin
         if (miss_count != TOTAL_MAX) miss_count++;
      end else begin
         near_end = (at_position <= cfg_shadow.end_zone) ||
                    (pos_ext + cfg_shadow.end_zone >= cfg_shadow.seq_length);
         parent = CODE_NONE;
         if (!near_end) adj_run = '0;
         if (beat.f_base == beat.h_base && beat.f_base != beat.l_base) parent = CODE_H;
         else if (beat.f_base == beat.l_base && beat.f_base != beat.h_base) parent = CODE_L;
         if (parent != CODE_NONE) begin
            if (parent != prev_parent) begin
               if (near_end) begin
                  if (pos_ext == {1'b0, prev_coded_pos} + 1'b1) begin
                     if (adj_run < RUN_NEEDED) adj_run++;
                  end else begin
                     adj_run = '0;
                  end
                  if (adj_run >= RUN_NEEDED) end_run_seen = 1'b1;
               end
               if (first_parent == CODE_NONE) first_parent = parent;
               if (switch_total < SWITCH_MAX) switch_total++;
            end
            prev_parent    = parent;
            prev_coded_pos = at_position;
         end
      end
      if (at_position != TOTAL_MAX) at_position++;
      if (beat.last) begin
         if (all_same) outcome.pattern_code = PAT_IDENTICAL;
         else if (miss_count > cfg_shadow.mismatch_limit) outcome.pattern_code = PAT_MISMATCH;
         else if (end_run_seen) outcome.pattern_code = PAT_END_RUN;
         else begin
            case (switch_total)
               3'd1: outcome.pattern_code = (first_parent == CODE_H) ? PAT_H_ONE : PAT_L_ONE;
               3'd2: outcome.pattern_code = (first_parent == CODE_H) ? PAT_H_TWO : PAT_L_TWO;
               3'd3: outcome.pattern_code = (first_parent == CODE_H) ? PAT_H_THREE : PAT_L_THREE;
               default: outcome.pattern_code = PAT_OTHER;
            endcase
         end
         outcome.mismatch_total = miss_count;
         pending_patterns = {pending_patterns, outcome};
         clear_lineage();
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_patterns.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat %h", rsp_data));
         end else begin
            oldest_pattern = pending_patterns.pop_front();
            if (rsp_data.pattern_code !== oldest_pattern.pattern_code)
               report_mismatch($sformatf("pattern_code %0d, want %0d",
                  rsp_data.pattern_code, oldest_pattern.pattern_code));
            if (rsp_data.mismatch_total !== oldest_pattern.mismatch_total)
               report_mismatch($sformatf("mismatch_total %0d, want %0d",
                  rsp_data.mismatch_total, oldest_pattern.mismatch_total));
         end
      end
   end

   // result sink with random stalls and one long hold
   initial begin : rsp_sink
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (quiet_mode) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 14);
         end
      end
   end

   function automatic req_item_type make_position(input logic [1:0] kind, input logic [7:0] f,
                                                   input logic [7:0] other, input logic last);
      req_item_type beat;
      beat.f_base = f;
      beat.last   = last;
      case (kind)
         KIND_H: begin
            beat.h_base = f;
            beat.l_base = other;
         end
         KIND_L: begin
            beat.h_base = other;
            beat.l_base = f;
         end
         KIND_MISMATCH: begin
            beat.h_base = other;
            beat.l_base = ($urandom_range(0, 1) && (~other != f)) ? ~other : other;
         end
         default: begin
            beat.h_base = f;
            beat.l_base = f;
         end
      endcase
      return beat;
   endfunction

   function automatic req_item_type random_position(input logic [1:0] kind, input logic last);
      logic [7:0] f;
      f = 8'($urandom_range(0, 255));
      return make_position(kind, f, f ^ 8'($urandom_range(1, 255)), last);
   endfunction

   task automatic send_beat(input req_item_type beat);
      if (!quiet_mode && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 14);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      track_position(beat);
      beats_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_patterns.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [CFG_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      case (index)
         CSR_SEQ_LENGTH:     cfg_shadow.seq_length     = value;
         CSR_END_ZONE:       cfg_shadow.end_zone       = value;
         CSR_MISMATCH_LIMIT: cfg_shadow.mismatch_limit = value;
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [CFG_W-1:0] length, input logic [CFG_W-1:0] zone,
                               input logic [CFG_W-1:0] limit);
      drain_results();
      write_register(CSR_SEQ_LENGTH, length);
      write_register(CSR_END_ZONE, zone);
      write_register(CSR_MISMATCH_LIMIT, limit);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_kinds(input logic [1:0] kinds[$]);
      foreach (kinds[i]) send_beat(random_position(kinds[i], i == kinds.size() - 1));
   endtask

   task automatic send_sequence(input int len, input seq_shape_type shape);
      logic [1:0] parent;
      logic [1:0] kind;
      int         roll;
      parent = $urandom_range(0, 1) ? KIND_H : KIND_L;
      for (int i = 0; i < len; i++) begin
         roll = $urandom_range(0, 99);
         case (shape)
            SHAPE_ALTERNATE: begin
               kind   = (roll < 4) ? KIND_MISMATCH : parent;
               parent = (parent == KIND_H) ? KIND_L : KIND_H;
            end
            SHAPE_RUNS: begin
               if (roll < 6) kind = KIND_MISMATCH;
               else if (roll < 14) kind = KIND_BOTH;
               else begin
                  if (roll >= 88) parent = (parent == KIND_H) ? KIND_L : KIND_H;
                  kind = parent;
               end
            end
            SHAPE_SCRAMBLED: kind = 2'($urandom_range(0, 3));
            default: kind = KIND_BOTH;
         endcase
         send_beat(random_position(kind, i == len - 1));
      end
   endtask

   task automatic test_reset_defaults();
      // single-position sequences at the reset register values
      send_beat(make_position(KIND_BOTH, 8'h00, 8'h00, 1'b1));
      send_beat(make_position(KIND_MISMATCH, 8'hFF, 8'h00, 1'b1));
      send_beat(make_position(KIND_H, 8'hFF, 8'h00, 1'b1));
      send_beat(make_position(KIND_L, 8'h00, 8'hFF, 1'b1));
   endtask

   task automatic test_directed_patterns();
      apply_config(16, 7, 2);
      // adjacent switches from position 0 inside the end zone
      send_kinds('{KIND_H, KIND_L, KIND_H, KIND_L, KIND_H, KIND_L, KIND_H, KIND_L});
      // both parents matched before the first coded position
      send_kinds('{KIND_BOTH, KIND_H, KIND_L});
      send_kinds('{KIND_L, KIND_H, KIND_L});
      send_kinds('{KIND_H, KIND_L, KIND_H});
      send_kinds('{KIND_L, KIND_H});
      // mismatches at the limit, no switch
      send_kinds('{KIND_MISMATCH, KIND_MISMATCH});
   endtask

   task automatic test_back_pressure();
      apply_config(6, 2, 1);
      quiet_mode    = 1'b1;
      long_hold_req = 1'b1;
      repeat (20) send_sequence(3, SHAPE_RUNS);
      quiet_mode = 1'b0;
   endtask

   task automatic test_long_sequence();
      apply_config(300, 15, 20);
      quiet_mode = 1'b1;
      send_sequence(400, SHAPE_RUNS);
      send_sequence(40, SHAPE_ALTERNATE);
      quiet_mode = 1'b0;
   endtask

   task automatic test_random_phases();
      int stop_at;
      int phase_end;
      int phase;
      int len;
      int roll;
      seq_shape_type shape;
      stop_at = beats_sent + RANDOM_BEATS;
      phase   = 0;
      while (beats_sent < stop_at) begin
         case (phase)
            0: apply_config(0, 0, 0);
            1: apply_config(TOTAL_MAX, TOTAL_MAX, TOTAL_MAX);
            2: apply_config(1, 0, 0);
            3: apply_config(CFG_W'(MAX_LEN_DEFAULT), 0, 1);
            default: apply_config(CFG_W'($urandom_range(8, 48)), CFG_W'($urandom_range(0, 12)),
                                  CFG_W'($urandom_range(0, 4)));
         endcase
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end && beats_sent < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) len = $urandom_range(1, 120);
            else if (cfg_shadow.seq_length >= 1 && cfg_shadow.seq_length <= 64)
               len = int'(cfg_shadow.seq_length) + $urandom_range(0, 6) - 3;
            else len = $urandom_range(1, 30);
            if (len < 1) len = 1;
            roll = $urandom_range(0, 99);
            if (roll < 50) shape = SHAPE_RUNS;
            else if (roll < 70) shape = SHAPE_ALTERNATE;
            else if (roll < 90) shape = SHAPE_SCRAMBLED;
            else shape = SHAPE_UNIFORM;
            send_sequence(len, shape);
         end
         phase++;
      end
   endtask

   initial begin
      cfg_shadow = '{seq_length: 21'd1, end_zone: 21'd0, mismatch_limit: 21'd0};
      clear_lineage();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_patterns();
      test_back_pressure();
      test_long_sequence();
      test_random_phases();
      drain_results();
      if (error_count == 0) begin
         $display("tb_parental_origin_pattern_classifier_unit: PASS");
      end else begin
         $display("tb_parental_origin_pattern_classifier_unit: FAIL");
      end
      $finish;
   end

endmodule
